/* sv/dfr_pkg.sv */
// shared types and constants of the websocket frame deframer
// depends on nothing; every module of the block imports it
package dfr_pkg;

   localparam int MESSAGE_LENGTH_WIDTH = 32;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [6:0] LEN_CODE16 = 7'd126;
   localparam logic [6:0] LEN_CODE64 = 7'd127;

   localparam logic [3:0] EXT16_BYTES    = 4'd2;
   localparam logic [3:0] EXT64_BYTES    = 4'd8;
   localparam logic [3:0] MASK_KEY_BYTES = 4'd4;

   localparam logic [3:0] OP_CONT   = 4'd0;
   localparam logic [3:0] OP_BINARY = 4'd2;
   localparam logic [3:0] OP_PING   = 4'd9;

   localparam logic CSR_CLIENT_MODE = 1'b0;
   localparam logic CSR_MAX_BYTES   = 1'b1;

   typedef enum logic [2:0] {
      PH_HEAD0,
      PH_HEAD1,
      PH_EXTLEN,
      PH_MASKKEY,
      PH_PAYLOAD
   } phase_type;

   typedef enum logic [1:0] {
      RK_PAYLOAD = 2'd0,
      RK_END     = 2'd1,
      RK_PONG    = 2'd2,
      RK_ERROR   = 2'd3
   } result_kind_type;

   typedef enum logic {
      ERR_UNMASKED = 1'b0,
      ERR_OVERSIZE = 1'b1
   } error_code_type;

   typedef struct packed {
      logic        client_mode;
      logic [31:0] max_message_bytes;
   } cfg_type;

   typedef struct packed {
      result_kind_type kind;
      logic [7:0]      raw_byte;
      logic [7:0]      key_byte;
      logic [3:0]      opcode;
      logic            eom;
      error_code_type  err;
   } entry_type;

endpackage

/* sv/dfr_front.sv */
// frame parser: takes stream bytes, tracks the frame header and message state,
// and pushes one result record per byte that causes one; uses dfr_pkg
module dfr_front
   import dfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_valid,
   input  logic [7:0] req_stream_byte,
   input  logic       q_full,
   output logic       push,
   output entry_type  push_entry
);

   localparam logic [64:0] LEN_MASK = (65'd1 << MESSAGE_LENGTH_WIDTH) - 65'd1;

   phase_type                       phase_ff, phase_in;
   logic                            final_ff, final_in;
   logic [3:0]                      opcode_ff, opcode_in;
   logic                            masked_ff, masked_in;
   logic [3:0]                      left_ff, left_in;
   logic [31:0]                     key_ff, key_in;
   logic [63:0]                     rem_ff, rem_in;
   logic [1:0]                      idx_ff, idx_in;
   logic [MESSAGE_LENGTH_WIDTH-1:0] total_ff, total_in;
   logic [3:0]                      latched_ff, latched_in;
   logic                            closed_ff, closed_in;

   logic        accept;
   logic        push_raw;
   logic [7:0]  b;
   logic [6:0]  code;
   logic        is_data;
   logic        mask_fail;
   logic        left_last;
   logic        ld_active;
   logic [63:0] ld_len;
   logic        ld_masked;
   logic [64:0] limit;
   logic [64:0] sum;
   logic        size_err;
   phase_type   ld_phase;
   logic [3:0]  lat_new;
   logic [7:0]  key_byte;

   assign accept = req_valid && !q_full;
   assign push   = push_raw && accept;
   assign b      = req_stream_byte;
   assign code   = b[6:0];

   // length resolution, shared by the short and extended length paths
   always_comb begin
      is_data   = opcode_ff <= OP_BINARY;
      mask_fail = is_data && !cfg.client_mode && !b[7];
      left_last = left_ff == 4'd1;
      ld_active = 1'b0;
      ld_len    = {rem_ff[55:0], b};
      ld_masked = masked_ff;
      if (!closed_ff) begin
         if (phase_ff == PH_HEAD1 && !mask_fail && code != LEN_CODE16
             && code != LEN_CODE64) begin
            ld_active = 1'b1;
            ld_len    = 64'(code);
            ld_masked = b[7];
         end else if (phase_ff == PH_EXTLEN && left_last) begin
            ld_active = 1'b1;
         end
      end
      limit    = (65'(cfg.max_message_bytes) > LEN_MASK) ? LEN_MASK
                                                         : 65'(cfg.max_message_bytes);
      sum      = 65'(total_ff) + 65'(ld_len);
      size_err = ld_active && is_data && (sum >= limit);
      if (size_err) begin
         ld_phase = phase_ff;
      end else if (ld_masked) begin
         ld_phase = PH_MASKKEY;
      end else if (ld_len != 64'd0) begin
         ld_phase = PH_PAYLOAD;
      end else begin
         ld_phase = PH_HEAD0;
      end
      lat_new = (latched_ff == OP_CONT && opcode_ff != OP_CONT) ? opcode_ff : latched_ff;
      unique case (idx_ff)
         2'd0: key_byte = key_ff[31:24];
         2'd1: key_byte = key_ff[23:16];
         2'd2: key_byte = key_ff[15:8];
         2'd3: key_byte = key_ff[7:0];
      endcase
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (!closed_ff) begin
         unique case (phase_ff)
            PH_HEAD0: phase_in = PH_HEAD1;
            PH_HEAD1: begin
               if (mask_fail) begin
                  phase_in = phase_ff;
               end else if (code == LEN_CODE16 || code == LEN_CODE64) begin
                  phase_in = PH_EXTLEN;
               end else begin
                  phase_in = ld_phase;
               end
            end
            PH_EXTLEN: begin
               if (left_last) phase_in = ld_phase;
            end
            PH_MASKKEY: begin
               if (left_last) phase_in = (rem_ff != 64'd0) ? PH_PAYLOAD : PH_HEAD0;
            end
            PH_PAYLOAD: begin
               if (rem_ff == 64'd1) phase_in = PH_HEAD0;
            end
            default: phase_in = PH_HEAD0;
         endcase
      end
   end

   // frame and message state, result record
   always_comb begin
      final_in   = final_ff;
      opcode_in  = opcode_ff;
      masked_in  = masked_ff;
      left_in    = left_ff;
      key_in     = key_ff;
      rem_in     = rem_ff;
      idx_in     = idx_ff;
      total_in   = total_ff;
      latched_in = latched_ff;
      closed_in  = closed_ff;
      push_raw   = 1'b0;
      push_entry = '{kind: RK_PAYLOAD, raw_byte: 8'd0, key_byte: 8'd0,
                     opcode: latched_ff, eom: 1'b0, err: ERR_UNMASKED};
      if (!closed_ff) begin
         unique case (phase_ff)
            PH_HEAD0: begin
               final_in  = b[7];
               opcode_in = b[3:0];
            end
            PH_HEAD1: begin
               masked_in = b[7];
               if (mask_fail) begin
                  closed_in       = 1'b1;
                  push_raw        = 1'b1;
                  push_entry.kind = RK_ERROR;
               end else begin
                  if (opcode_ff == OP_PING) begin
                     push_raw        = 1'b1;
                     push_entry.kind = RK_PONG;
                  end
                  rem_in = 64'(code);
                  if (code == LEN_CODE16) begin
                     rem_in  = 64'd0;
                     left_in = EXT16_BYTES;
                  end else if (code == LEN_CODE64) begin
                     rem_in  = 64'd0;
                     left_in = EXT64_BYTES;
                  end
               end
            end
            PH_EXTLEN: begin
               rem_in  = ld_len;
               left_in = left_ff - 4'd1;
            end
            PH_MASKKEY: begin
               key_in  = {key_ff[23:0], b};
               left_in = left_ff - 4'd1;
               if (left_last) begin
                  idx_in = 2'd0;
                  if (rem_ff == 64'd0 && is_data && final_ff) begin
                     push_raw        = 1'b1;
                     push_entry.kind = RK_END;
                     push_entry.eom  = 1'b1;
                     total_in        = '0;
                     latched_in      = OP_CONT;
                  end
               end
            end
            PH_PAYLOAD: begin
               idx_in = idx_ff + 2'd1;
               rem_in = rem_ff - 64'd1;
               if (is_data) begin
                  push_raw            = 1'b1;
                  push_entry.raw_byte = b;
                  push_entry.key_byte = masked_ff ? key_byte : 8'd0;
                  push_entry.eom      = (rem_ff == 64'd1) && final_ff;
                  if (push_entry.eom) begin
                     total_in   = '0;
                     latched_in = OP_CONT;
                  end
               end
            end
            default: ;
         endcase

         if (ld_active) begin
            if (size_err) begin
               closed_in       = 1'b1;
               push_raw        = 1'b1;
               push_entry.kind = RK_ERROR;
               push_entry.err  = ERR_OVERSIZE;
            end else begin
               if (is_data) begin
                  total_in   = sum[MESSAGE_LENGTH_WIDTH-1:0];
                  latched_in = lat_new;
               end
               if (ld_masked) begin
                  left_in = MASK_KEY_BYTES;
                  key_in  = 32'd0;
               end else begin
                  idx_in = 2'd0;
                  if (ld_len == 64'd0 && is_data && final_ff) begin
                     push_raw          = 1'b1;
                     push_entry.kind   = RK_END;
                     push_entry.eom    = 1'b1;
                     push_entry.opcode = lat_new;
                     total_in          = '0;
                     latched_in        = OP_CONT;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEAD0;
         final_ff   <= 1'b0;
         opcode_ff  <= 4'd0;
         masked_ff  <= 1'b0;
         left_ff    <= 4'd0;
         key_ff     <= 32'd0;
         rem_ff     <= 64'd0;
         idx_ff     <= 2'd0;
         total_ff   <= '0;
         latched_ff <= 4'd0;
         closed_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         final_ff   <= final_in;
         opcode_ff  <= opcode_in;
         masked_ff  <= masked_in;
         left_ff    <= left_in;
         key_ff     <= key_in;
         rem_ff     <= rem_in;
         idx_ff     <= idx_in;
         total_ff   <= total_in;
         latched_ff <= latched_in;
         closed_ff  <= closed_in;
      end
   end

endmodule

/* sv/dfr_fifo.sv */
// short result queue between the parser and the output stage
// holds entry_type records from dfr_pkg
module dfr_fifo
   import dfr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      full,
   output logic      empty
);

   entry_type             slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;

   assign full  = count_ff == FIFO_CNT_W'(FIFO_DEPTH);
   assign empty = count_ff == '0;
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? FIFO_PTR_W'((32'(wr_ptr_ff) + 1) % FIFO_DEPTH) : wr_ptr_ff;
      rd_ptr_in = pop  ? FIFO_PTR_W'((32'(rd_ptr_ff) + 1) % FIFO_DEPTH) : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

/* sv/dfr_back.sv */
// output stage: takes records from the result queue, applies the mask key
// and holds each result until its transfer; uses dfr_pkg
module dfr_back
   import dfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  entry_type  head,
   input  logic       q_empty,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_result_kind,
   output logic [7:0] rsp_payload_byte,
   output logic [3:0] rsp_message_opcode,
   output logic       rsp_end_of_message,
   output logic       rsp_error_code
);

   logic       valid_ff, valid_in;
   logic [1:0] kind_ff;
   logic [7:0] byte_ff;
   logic [3:0] opcode_ff;
   logic       eom_ff;
   logic       err_ff;

   assign pop      = !q_empty && (!valid_ff || !rsp_stall);
   assign valid_in = pop || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff   <= head.kind;
         byte_ff   <= head.raw_byte ^ head.key_byte;
         opcode_ff <= head.opcode;
         eom_ff    <= head.eom;
         err_ff    <= head.err;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_result_kind    = kind_ff;
   assign rsp_payload_byte   = byte_ff;
   assign rsp_message_opcode = opcode_ff;
   assign rsp_end_of_message = eom_ff;
   assign rsp_error_code     = err_ff;

endmodule

/* sv/websocket_frame_deframer.sv */
// websocket frame deframer top level: configuration registers, parser,
// result queue and output stage; uses dfr_pkg, dfr_front, dfr_fifo, dfr_back
//
//   channel  ports              transfer when
//   input    req_valid/stall    req_valid && !req_stall, one stream byte
//   result   rsp_valid/stall    rsp_valid && !rsp_stall, one result record
//   config   csr_ apb           csr_psel && csr_penable && csr_pwrite
//
// one byte per cycle while req_stall is low: the parser resolves each byte
// combinationally; a result passes through the queue, then the output register.
// req_stall is high only while the four-entry result queue is full.
// synchronous reset returns the parser to the first head byte and empties
// the queue; the stream stays closed after an error until reset.
module websocket_frame_deframer
   import dfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [3:0]  rsp_message_opcode,
   output logic        rsp_end_of_message,
   output logic        rsp_error_code,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type   cfg_ff, cfg_in;
   logic      csr_write;
   logic      fe_push;
   entry_type fe_entry;
   entry_type q_head;
   logic      q_full;
   logic      q_empty;
   logic      q_pop;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_MAX_BYTES) ? cfg_ff.max_message_bytes
                                                       : {31'd0, cfg_ff.client_mode};

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            CSR_CLIENT_MODE: cfg_in.client_mode       = csr_pwdata[0];
            CSR_MAX_BYTES:   cfg_in.max_message_bytes = csr_pwdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{client_mode: 1'b0, max_message_bytes: 32'd33554432};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = q_full;

   dfr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_stream_byte (req_stream_byte),
      .q_full          (q_full),
      .push            (fe_push),
      .push_entry      (fe_entry)
   );

   dfr_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (fe_push),
      .push_entry (fe_entry),
      .pop        (q_pop),
      .head       (q_head),
      .full       (q_full),
      .empty      (q_empty)
   );

   dfr_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (q_head),
      .q_empty            (q_empty),
      .pop                (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_message_opcode (rsp_message_opcode),
      .rsp_end_of_message (rsp_end_of_message),
      .rsp_error_code     (rsp_error_code)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      fe_push |-> !q_full)
      else $error("result pushed into a full queue");

   a_closed_after_error: assert property (@(posedge clock) disable iff (reset)
      (fe_push && fe_entry.kind == RK_ERROR) |=> !fe_push)
      else $error("result produced after an error closed the stream");

   a_queue_drains: assert property (@(posedge clock) disable iff (reset)
      (!q_empty && !rsp_stall) |=> rsp_valid)
      else $error("queued result not moved to the output register");

endmodule

/* verif/websocket_frame_deframer_checker.sv */
// result checker for the websocket frame deframer: watches the stream, result and
// register ports, predicts every result and compares it with what comes out
// depends on dfr_pkg for the phase, result kind, error code and length constants
module websocket_frame_deframer_checker
   import dfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_result_kind,
   input  logic [7:0]  rsp_payload_byte,
   input  logic [3:0]  rsp_message_opcode,
   input  logic        rsp_end_of_message,
   input  logic        rsp_error_code,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatch_count,
   output int          pending_results,
   output int          results_checked
);

   localparam logic [63:0] LENGTH_MASK = (MESSAGE_LENGTH_WIDTH >= 64) ? '1 :
      ((64'd1 << MESSAGE_LENGTH_WIDTH) - 64'd1);

   typedef struct {
      result_kind_type kind;
      logic [7:0]      data;
      logic [3:0]      opcode;
      logic            eom;
      error_code_type  err;
   } deframed_result_type;

   deframed_result_type expected_results[$];

   logic        client_mode_q;
   logic [31:0] max_bytes_q;

   phase_type   phase;
   logic        final_bit;
   logic [3:0]  frame_op;
   logic        masked;
   logic [3:0]  len_left;
   logic [31:0] key;
   logic [63:0] remaining;
   logic [1:0]  key_idx;
   logic [63:0] msg_total;
   logic [3:0]  msg_opcode;
   logic        closed;

   int mismatches;
   int checked;

   function automatic logic is_data_frame();
      return frame_op <= OP_BINARY;
   endfunction

   function automatic void expect_result(result_kind_type kind, logic [7:0] data, logic eom,
                                         error_code_type err);
      deframed_result_type r;
      r.kind = kind;
      r.data = data;
      r.opcode = msg_opcode;
      r.eom = eom;
      r.err = err;
      expected_results.push_back(r);
   endfunction

   function automatic void clear_message();
      msg_total = '0;
      msg_opcode = OP_CONT;
   endfunction

   function automatic void enter_payload();
      key_idx = '0;
      if (remaining != 0) begin
         phase = PH_PAYLOAD;
         return;
      end
      phase = PH_HEAD0;
      if (is_data_frame() && final_bit) begin
         expect_result(RK_END, 8'h00, 1'b1, ERR_UNMASKED);
         clear_message();
      end
   endfunction

   function automatic void frame_length_known();
      logic [63:0] limit;
      if (is_data_frame()) begin
         limit = {32'd0, max_bytes_q};
         if (limit > LENGTH_MASK) limit = LENGTH_MASK;
         if (remaining >= limit || msg_total >= limit - remaining) begin
            closed = 1'b1;
            expect_result(RK_ERROR, 8'h00, 1'b0, ERR_OVERSIZE);
            return;
         end
         msg_total = (msg_total + remaining) & LENGTH_MASK;
         if (msg_opcode == OP_CONT && frame_op != OP_CONT) msg_opcode = frame_op;
      end
      if (masked) begin
         phase = PH_MASKKEY;
         len_left = MASK_KEY_BYTES;
         key = '0;
         return;
      end
      enter_payload();
   endfunction

   function automatic void parse_byte(logic [7:0] b);
      logic [7:0] key_byte;
      logic       eom;
      int         shift;
      if (closed) return;
      case (phase)
         PH_HEAD0: begin
            final_bit = b[7];
            frame_op = b[3:0];
            phase = PH_HEAD1;
         end
         PH_HEAD1: begin
            masked = b[7];
            if (is_data_frame() && !client_mode_q && !masked) begin
               closed = 1'b1;
               expect_result(RK_ERROR, 8'h00, 1'b0, ERR_UNMASKED);
               return;
            end
            if (frame_op == OP_PING) expect_result(RK_PONG, 8'h00, 1'b0, ERR_UNMASKED);
            remaining = '0;
            if (b[6:0] == LEN_CODE16) begin
               len_left = EXT16_BYTES;
               phase = PH_EXTLEN;
            end else if (b[6:0] == LEN_CODE64) begin
               len_left = EXT64_BYTES;
               phase = PH_EXTLEN;
            end else begin
               remaining = {57'd0, b[6:0]};
               frame_length_known();
            end
         end
         PH_EXTLEN: begin
            remaining = {remaining[55:0], b};
            len_left = len_left - 4'd1;
            if (len_left == 0) frame_length_known();
         end
         PH_MASKKEY: begin
            key = {key[23:0], b};
            len_left = len_left - 4'd1;
            if (len_left == 0) enter_payload();
         end
         PH_PAYLOAD: begin
            shift = 24 - 8 * int'(key_idx);
            key_byte = masked ? 8'(key >> shift) : 8'h00;
            key_idx = key_idx + 2'd1;
            remaining = remaining - 64'd1;
            eom = 1'b0;
            if (remaining == 0) begin
               phase = PH_HEAD0;
               eom = final_bit;
            end
            if (is_data_frame()) begin
               expect_result(RK_PAYLOAD, b ^ key_byte, eom, ERR_UNMASKED);
               if (eom) clear_message();
            end
         end
         default: phase = PH_HEAD0;
      endcase
   endfunction

   function automatic void check_result();
      deframed_result_type want;
      checked++;
      if (expected_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: kind %0d byte %h opcode %0d eom %0d err %0d",
                     rsp_result_kind, rsp_payload_byte, rsp_message_opcode,
                     rsp_end_of_message, rsp_error_code);
         return;
      end
      want = expected_results.pop_front();
      if (rsp_result_kind !== want.kind || rsp_payload_byte !== want.data ||
          rsp_message_opcode !== want.opcode || rsp_end_of_message !== want.eom ||
          rsp_error_code !== want.err) begin
         mismatches++;
         if (mismatches <= 10)
            $display("got/exp kind %0d/%0d byte %h/%h op %0d/%0d eom %0d/%0d err %0d/%0d",
                     rsp_result_kind, want.kind, rsp_payload_byte, want.data,
                     rsp_message_opcode, want.opcode, rsp_end_of_message, want.eom,
                     rsp_error_code, want.err);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_results.delete();
         client_mode_q = 1'b0;
         max_bytes_q = 32'd33554432;
         phase = PH_HEAD0;
         final_bit = 1'b0;
         frame_op = OP_CONT;
         masked = 1'b0;
         len_left = '0;
         key = '0;
         remaining = '0;
         key_idx = '0;
         closed = 1'b0;
         clear_message();
         mismatches = 0;
         checked = 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result();
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[2])
               CSR_CLIENT_MODE: client_mode_q = csr_pwdata[0];
               CSR_MAX_BYTES:   max_bytes_q = csr_pwdata;
            endcase
         end
         if (req_valid && !req_stall) parse_byte(req_stream_byte);
      end
      mismatch_count <= mismatches;
      pending_results <= expected_results.size();
      results_checked <= checked;
   end

endmodule

/* verif/websocket_frame_deframer_tb.sv */
// testbench top for the websocket frame deframer: clock, reset, register writes,
// directed and random frame streams, result-side stalls and the final verdict
// depends on dfr_pkg, websocket_frame_deframer and websocket_frame_deframer_checker
module websocket_frame_deframer_tb;
   import dfr_pkg::*;

   localparam logic [3:0] OP_TEXT = 4'd1;
   localparam logic [3:0] OP_PONG = 4'd10;

   typedef enum int {
      CLOSE_UNMASKED,
      CLOSE_TOP_BIT_LENGTH,
      CLOSE_MESSAGE_TOTAL
   } close_cause_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_stream_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_payload_byte;
   logic [3:0]  rsp_message_opcode;
   logic        rsp_end_of_message;
   logic        rsp_error_code;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int mismatches;
   int pending;
   int checked;

   bit          idle_on = 1'b0;
   logic        client_now = 1'b0;
   longint      limit_now = 33554432;
   longint      msg_bytes = 0;
   bit          in_msg = 1'b0;
   int          bytes_sent = 0;
   int          frames_sent = 0;
   int          settings_used = 1;

   websocket_frame_deframer dut (.*);

   websocket_frame_deframer_checker checker_i (
      .clock, .reset, .req_valid, .req_stall, .req_stream_byte,
      .rsp_valid, .rsp_stall, .rsp_result_kind, .rsp_payload_byte, .rsp_message_opcode,
      .rsp_end_of_message, .rsp_error_code,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .mismatch_count(mismatches), .pending_results(pending), .results_checked(checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end

   // one byte transfer, with an optional idle burst before it
   task automatic send_byte(input logic [7:0] b);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_stream_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_word(input logic [31:0] w);
      int i;
      for (i = 3; i >= 0; i--) send_byte(w[8*i +: 8]);
   endtask

   task automatic send_head(input logic fin, input logic [3:0] op, input logic masked,
                            input logic [6:0] code);
      send_byte({fin, 3'($urandom_range(0, 7)), op});
      send_byte({masked, code});
   endtask

   // wait until every predicted result has come out or the wait times out, then let the pipeline settle
   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending != 0 && waited < 5000);
      repeat (6) @(posedge clock);
   endtask

   task automatic send_frame(input logic [3:0] op, input logic fin, input int unsigned want);
      logic        data_frame;
      logic        masked;
      longint      room;
      longint      len;
      longint      n;
      int unsigned form;
      int          i;
      logic [6:0]  code;
      data_frame = (op <= OP_BINARY);
      len = want;
      if (data_frame) begin
         room = limit_now - 1 - msg_bytes;
         if (len > room) len = room;
      end
      masked = (data_frame && !client_now) ? 1'b1 : 1'($urandom_range(0, 1));
      if (len > 125) form = $urandom_range(1, 2);
      else form = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
      code = (form == 0) ? 7'(len) : (form == 1) ? LEN_CODE16 : LEN_CODE64;
      send_head(fin, op, masked, code);
      if (form == 1) begin
         send_byte(8'(len >> 8));
         send_byte(8'(len));
      end else if (form == 2) begin
         for (i = 7; i >= 0; i--) send_byte(8'(len >> (8 * i)));
      end
      if (masked) begin
         case ($urandom_range(0, 7))
            0:       send_word(32'h0000_0000);
            1:       send_word(32'hFFFF_FFFF);
            default: send_word($urandom);
         endcase
      end
      for (n = 0; n < len; n++) send_byte(8'($urandom));
      frames_sent++;
      if (data_frame) begin
         if (fin) begin
            msg_bytes = 0;
            in_msg = 1'b0;
         end else begin
            msg_bytes += len;
            in_msg = 1'b1;
         end
      end
   endtask

   task automatic random_frame();
      logic [3:0]  op;
      int unsigned len;
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) len = $urandom_range(0, 1) ? 125 : $urandom_range(126, 300);
      else if (pick < 4) len = 0;
      else len = $urandom_range(1, 16);
      if ($urandom_range(0, 99) < 65) begin
         if (in_msg)
            op = ($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? OP_TEXT : OP_BINARY)
                                              : OP_CONT;
         else
            op = ($urandom_range(0, 5) == 0) ? OP_CONT
                                              : ($urandom_range(0, 1) ? OP_TEXT : OP_BINARY);
      end else begin
         op = ($urandom_range(0, 2) == 0) ? OP_PING : 4'($urandom_range(3, 15));
      end
      send_frame(op, 1'($urandom_range(0, 1)), len);
   endtask

   task automatic close_message();
      if (in_msg) send_frame(OP_CONT, 1'b1, 0);
   endtask

   task automatic write_csr(input logic index, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic apply_setting(input logic client, input logic [31:0] max_bytes);
      close_message();
      drain();
      write_csr(CSR_CLIENT_MODE, {31'd0, client});
      write_csr(CSR_MAX_BYTES, max_bytes);
      client_now = client;
      limit_now = max_bytes;
      settings_used++;
   endtask

   task automatic run_random(input int amount);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < amount) begin
         idle_on = ($urandom_range(0, 3) != 0);
         random_frame();
         if ($urandom_range(0, 39) == 0) drain();
      end
   endtask

   initial begin
      close_cause_type cause;
      string           cause_text;
      int              limit_pick;
      int              leftover;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // server mode after reset: masked text, pong dropped, ping, empty stray continuation
      idle_on = 1'b1;
      send_head(1'b1, OP_TEXT, 1'b1, 7'd2);
      send_word(32'h1122_3344);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_head(1'b1, OP_PONG, 1'b0, 7'd1);
      send_byte(8'h77);
      send_head(1'b1, OP_PING, 1'b0, 7'd0);
      send_head(1'b1, OP_CONT, 1'b1, 7'd0);
      send_word(32'h0000_0000);

      apply_setting(1'b1, 32'hFFFF_FFFF);
      run_random(80);
      apply_setting(1'b0, 32'd1);
      run_random(40);
      apply_setting(1'b1, $urandom_range(20, 200));
      run_random(80);
      apply_setting(1'b0, $urandom_range(300, 100000));
      run_random(100);
      apply_setting(1'($urandom_range(0, 1)), $urandom | 32'd1);
      run_random(100);

      // last part: no idling, three random frames, then one fatal frame and bytes the closed stream drops
      cause = close_cause_type'($urandom_range(0, 2));
      limit_pick = (cause == CLOSE_MESSAGE_TOTAL) ? $urandom_range(10, 60)
                                                  : $urandom_range(1000, 1 << 24);
      apply_setting(1'b0, 32'(limit_pick));
      idle_on = 1'b0;
      repeat (3) random_frame();
      case (cause)
         CLOSE_UNMASKED: begin
            cause_text = "an unmasked data frame in server mode";
            send_head(1'($urandom_range(0, 1)), OP_TEXT, 1'b0, 7'($urandom_range(0, 127)));
         end
         CLOSE_TOP_BIT_LENGTH: begin
            cause_text = "a 64-bit length with its top bit set";
            send_head(1'b1, OP_BINARY, 1'b1, LEN_CODE64);
            send_byte(8'h80 | 8'($urandom_range(0, 127)));
            repeat (7) send_byte(8'($urandom));
         end
         default: begin
            cause_text = "a message total reaching the limit";
            close_message();
            send_frame(OP_TEXT, 1'b0, limit_pick - 3);
            send_head(1'b1, OP_CONT, 1'b1, 7'd3);
         end
      endcase
      repeat (12) send_byte(8'($urandom));

      drain();
      leftover = pending;
      if (leftover != 0) $display("%0d expected results never arrived", leftover);
      $display("%0d stream bytes in %0d frames over %0d register settings, %0d results checked",
               bytes_sent, frames_sent, settings_used, checked);
      $display("stream closed at the end by %s", cause_text);
      if (mismatches == 0 && leftover == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
sv/dfr_pkg.sv
sv/dfr_front.sv
sv/dfr_fifo.sv
sv/dfr_back.sv
sv/websocket_frame_deframer.sv
verif/websocket_frame_deframer_checker.sv
verif/websocket_frame_deframer_tb.sv
